// ----- rtl/sdt_pkg.sv -----
`default_nettype none
package sdt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0]        count;
		logic signed [7:0]  rssi;
		logic [47:0]        address;
	} entry_t;

	typedef struct packed {
		logic               hit;
		logic               new_entry;
		logic               evicted;
		logic [3:0]         slot;
		logic [15:0]        occurrences;
		logic [47:0]        entry_address;
		logic signed [7:0]  entry_rssi;
		logic [4:0]         entry_count;
		logic               entry_valid;
	} res_t;

endpackage
`default_nettype wire

// ----- rtl/sdt_mem.sv -----
`default_nettype none
module sdt_mem #(
	parameter int Depth = 16,
	parameter int IdxW  = 4
) (
	input  wire                 clk,
	input  wire                 we,
	input  wire [IdxW-1:0]      waddr,
	input  sdt_pkg::entry_t     wdata,
	input  wire [IdxW-1:0]      raddr,
	output sdt_pkg::entry_t     rdata
);
	import sdt_pkg::*;

	entry_t mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/sdt_ctrl.sv -----
`default_nettype none
module sdt_ctrl #(
	parameter int Depth = 16,
	parameter int IdxW  = 4,
	parameter int FillW = 5
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 in_mode,
	input  wire [47:0]          in_address,
	input  wire signed [7:0]    in_rssi,
	input  wire [3:0]           in_read_index,
	output logic                mem_we,
	output logic [IdxW-1:0]     mem_waddr,
	output sdt_pkg::entry_t     mem_wdata,
	output logic [IdxW-1:0]     mem_raddr,
	input  sdt_pkg::entry_t     mem_rdata,
	output logic                res_valid,
	input  wire                 res_ready,
	output sdt_pkg::res_t       res
);
	import sdt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_APPEND = 6'b000100,
		ST_READ   = 6'b001000,
		ST_RDATA  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [47:0]        addr_q;
	logic signed [7:0]  rssi_q;
	logic [3:0]         ridx_q;
	logic [IdxW-1:0]    scan_q, scan_d;
	logic               iss_q, iss_d;
	logic               pend_s1;
	logic               plast_s1;
	logic [IdxW-1:0]    pidx_s1;
	logic [IdxW-1:0]    best_idx_q, best_idx_d;
	logic [15:0]        best_cnt_q, best_cnt_d;
	logic [FillW-1:0]   fill_q, fill_d;
	res_t               res_q, res_d;

	logic               accept;
	logic               read_ok;
	logic               last_iss;
	logic               match;
	logic               take_cur;
	logic [IdxW-1:0]    sel_idx;
	logic               do_append;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	assign read_ok  = (32'(in_read_index) < 32'(fill_q)) && (32'(in_read_index) < Depth);
	assign last_iss = (32'(scan_q) + 32'd1 == 32'(fill_q));
	assign match    = (mem_rdata.address == addr_q);
	// first smallest count wins: the first slot seeds the minimum
	assign take_cur = (pidx_s1 == '0) || (mem_rdata.count < best_cnt_q);
	assign sel_idx  = take_cur ? pidx_s1 : best_idx_q;

	always_comb begin
		state_d    = state_q;
		scan_d     = scan_q;
		iss_d      = iss_q;
		best_idx_d = best_idx_q;
		best_cnt_d = best_cnt_q;
		fill_d     = fill_q;
		res_d      = res_q;
		mem_we     = 1'b0;
		mem_waddr  = pidx_s1;
		mem_wdata  = '{count: 16'd1, rssi: rssi_q, address: addr_q};
		mem_raddr  = scan_q;
		do_append  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_mode) begin
						if (read_ok) begin
							state_d = ST_READ;
						end else begin
							res_d = '{hit: 1'b0, new_entry: 1'b0, evicted: 1'b0,
								slot: in_read_index, occurrences: '0,
								entry_address: '0, entry_rssi: '0,
								entry_count: 5'(fill_q), entry_valid: 1'b0};
							state_d = ST_DONE;
						end
					end else if (fill_q == '0) begin
						state_d = ST_APPEND;
					end else begin
						scan_d  = '0;
						iss_d   = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (iss_q) begin
					scan_d = scan_q + 1'b1;
					if (last_iss) begin
						iss_d = 1'b0;
					end
				end
				if (pend_s1) begin
					if (take_cur) begin
						best_idx_d = pidx_s1;
						best_cnt_d = mem_rdata.count;
					end
					if (match) begin
						mem_we    = 1'b1;
						mem_waddr = pidx_s1;
						mem_wdata.count = (mem_rdata.count == COUNT_MAX) ?
							COUNT_MAX : mem_rdata.count + 16'd1;
						res_d = '{hit: 1'b1, new_entry: 1'b0, evicted: 1'b0,
							slot: 4'(pidx_s1), occurrences: mem_wdata.count,
							entry_address: addr_q, entry_rssi: rssi_q,
							entry_count: 5'(fill_q), entry_valid: 1'b0};
						iss_d   = 1'b0;
						state_d = ST_DONE;
					end else if (plast_s1) begin
						if (32'(fill_q) < Depth) begin
							do_append = 1'b1;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = sel_idx;
							res_d = '{hit: 1'b0, new_entry: 1'b1, evicted: 1'b1,
								slot: 4'(sel_idx), occurrences: 16'd1,
								entry_address: addr_q, entry_rssi: rssi_q,
								entry_count: 5'(fill_q), entry_valid: 1'b0};
							state_d = ST_DONE;
						end
					end
				end
			end
			ST_APPEND: begin
				do_append = 1'b1;
			end
			ST_READ: begin
				mem_raddr = IdxW'(ridx_q);
				state_d   = ST_RDATA;
			end
			ST_RDATA: begin
				res_d = '{hit: 1'b0, new_entry: 1'b0, evicted: 1'b0,
					slot: ridx_q, occurrences: mem_rdata.count,
					entry_address: mem_rdata.address, entry_rssi: mem_rdata.rssi,
					entry_count: 5'(fill_q), entry_valid: 1'b1};
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (do_append) begin
			mem_we    = 1'b1;
			mem_waddr = IdxW'(fill_q);
			fill_d    = fill_q + 1'b1;
			res_d = '{hit: 1'b0, new_entry: 1'b1, evicted: 1'b0,
				slot: 4'(fill_q), occurrences: 16'd1,
				entry_address: addr_q, entry_rssi: rssi_q,
				entry_count: 5'(fill_d), entry_valid: 1'b0};
			state_d = ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			iss_q    <= 1'b0;
			pend_s1  <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			iss_q    <= iss_d;
			pend_s1  <= iss_q && (state_q == ST_SCAN) && (state_d == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= in_address;
			rssi_q <= in_rssi;
			ridx_q <= in_read_index;
		end
		scan_q     <= scan_d;
		pidx_s1    <= scan_q;
		plast_s1   <= last_iss;
		best_idx_q <= best_idx_d;
		best_cnt_q <= best_cnt_d;
		res_q      <= res_d;
	end

endmodule
`default_nettype wire

// ----- rtl/seen_device_table_lfu.sv -----
`default_nettype none
// Table of seen device addresses with least-frequently-used replacement. One beat in,
// one beat out. A report beat scans the filled slots one per cycle through the single
// read port of the table memory, then writes the hit, appended or evicted slot; a hit
// ends the scan early. A read-back beat reads the addressed slot back through the same
// port unless that slot is not filled. No new beat is taken until the last result has
// gone to the output register, and a result that waits downstream holds the input off.
// Slots are not cleared at reset; only filled slots are ever returned.
module seen_device_table_lfu (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire         s_tuser,        // mode
	input  wire [63:0]  s_tdata,        // address[47:0], rssi[55:48], read_index[59:56]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [3:0]  m_tuser,        // hit, new_entry, evicted, entry_valid
	output logic [87:0] m_tdata         // slot, occurrences, entry_address, entry_rssi,
	                                    // entry_count
);
	import sdt_pkg::*;

	localparam int TableDepth = TABLE_DEPTH;
	localparam int IdxW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int FillW = $clog2(TableDepth + 1);

	logic               mem_we;
	logic [IdxW-1:0]    mem_waddr;
	entry_t             mem_wdata;
	logic [IdxW-1:0]    mem_raddr;
	entry_t             mem_rdata;
	logic               res_valid;
	logic               res_ready;
	res_t               res;
	logic               out_vld_q;
	res_t               out_q;

	sdt_ctrl #(
		.Depth (TableDepth),
		.IdxW  (IdxW),
		.FillW (FillW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_mode       (s_tuser),
		.in_address    (s_tdata[47:0]),
		.in_rssi       (s_tdata[55:48]),
		.in_read_index (s_tdata[59:56]),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res)
	);

	sdt_mem #(
		.Depth (TableDepth),
		.IdxW  (IdxW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: free when empty or being drained this cycle
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = {out_q.entry_valid, out_q.evicted, out_q.new_entry, out_q.hit};
	assign m_tdata  = {7'd0, out_q.entry_count, out_q.entry_rssi, out_q.entry_address,
		out_q.occurrences, out_q.slot};

endmodule
`default_nettype wire

// ----- rtl/sdt_chk.sv -----
`default_nettype none
module sdt_chk (
	input wire         clk,
	input wire         arst_n,
	input wire         s_tvalid,
	input wire         s_tready,
	input wire         s_tuser,
	input wire [63:0]  s_tdata,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [3:0]   m_tuser,
	input wire [87:0]  m_tdata
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one item in flight: no beat taken right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]) && (!m_tuser[2] || m_tuser[1])
			&& (!m_tuser[3] || (m_tuser[2:0] == 3'b000)))
		else $error("inconsistent result flags");

	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[19:4] == 16'd1)
		else $error("new entry without count one");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[19:4] != 16'd0 && m_tdata[80:76] != 5'd0)
		else $error("hit on an empty table or with zero count");

	// sticking the checker onto the top level
endmodule

bind seen_device_table_lfu sdt_chk u_chk (.*);
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
	import sdt_pkg::*;

	localparam bit MODE_REPORT = 1'b0;
	localparam bit MODE_READ = 1'b1;
	localparam int POOL_SIZE = 28;
	localparam int SCAN_LATENCY = TABLE_DEPTH + 4;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	// Mirror of the device table; predicts one result per accepted beat.
	class sighting_board;
		entry_t seen[TABLE_DEPTH];
		logic [4:0] filled;
		res_t expected_q[$];
		int failures;

		function new();
			filled = '0;
			failures = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void note_beat(logic mode, logic [47:0] addr, logic signed [7:0] rssi,
				logic [3:0] idx);
			res_t r;
			int k;
			int best;
			bit found;
			r = '0;
			found = 0;
			best = 0;
			if (mode == MODE_READ) begin
				r.slot = idx;
				r.entry_count = filled;
				if (idx < filled) begin
					r.entry_valid = 1'b1;
					r.occurrences = seen[idx].count;
					r.entry_address = seen[idx].address;
					r.entry_rssi = seen[idx].rssi;
				end
			end else begin
				for (k = 0; k < filled; k++) begin
					if (!found && seen[k].address == addr) begin
						found = 1;
						best = k;
					end
				end
				if (found) begin
					// saturate the sighting count
					if (seen[best].count != COUNT_MAX)
						seen[best].count = seen[best].count + 16'd1;
					seen[best].rssi = rssi;
					r.hit = 1'b1;
				end else begin
					if (filled < TABLE_DEPTH) begin
						best = int'(filled);
						filled = filled + 5'd1;
					end else begin
						// first slot holding the smallest count loses
						best = 0;
						for (k = 1; k < TABLE_DEPTH; k++)
							if (seen[k].count < seen[best].count)
								best = k;
						r.evicted = 1'b1;
					end
					seen[best].address = addr;
					seen[best].rssi = rssi;
					seen[best].count = 16'd1;
					r.new_entry = 1'b1;
				end
				r.slot = best[3:0];
				r.occurrences = seen[best].count;
				r.entry_address = seen[best].address;
				r.entry_rssi = seen[best].rssi;
				r.entry_count = filled;
			end
			expected_q.push_back(r);
		endfunction

		function void check_beat(logic [3:0] tuser, logic [87:0] tdata);
			res_t got;
			res_t want;
			got.hit = tuser[0];
			got.new_entry = tuser[1];
			got.evicted = tuser[2];
			got.entry_valid = tuser[3];
			got.slot = tdata[3:0];
			got.occurrences = tdata[19:4];
			got.entry_address = tdata[67:20];
			got.entry_rssi = tdata[75:68];
			got.entry_count = tdata[80:76];
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result beat: slot=%0d addr=%h", got.slot,
						got.entry_address);
				return;
			end
			want = expected_q.pop_front();
			if (got.hit !== want.hit || got.new_entry !== want.new_entry ||
					got.evicted !== want.evicted || got.slot !== want.slot ||
					got.occurrences !== want.occurrences ||
					got.entry_address !== want.entry_address ||
					got.entry_rssi !== want.entry_rssi ||
					got.entry_count !== want.entry_count ||
					got.entry_valid !== want.entry_valid) begin
				failures++;
				if (failures <= 10) begin
					$write("mismatch exp: hit=%b new=%b ev=%b slot=%0d occ=%0d ",
						want.hit, want.new_entry, want.evicted, want.slot, want.occurrences);
					$display("addr=%h rssi=%0d cnt=%0d vld=%b",
						want.entry_address, want.entry_rssi, want.entry_count, want.entry_valid);
					$write("         got: hit=%b new=%b ev=%b slot=%0d occ=%0d ",
						got.hit, got.new_entry, got.evicted, got.slot, got.occurrences);
					$display("addr=%h rssi=%0d cnt=%0d vld=%b",
						got.entry_address, got.entry_rssi, got.entry_count, got.entry_valid);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tuser = 1'b0;
	logic [63:0] s_tdata = '0;
	logic m_tready = 1'b0;
	wire s_tready;
	wire m_tvalid;
	wire [3:0] m_tuser;
	wire [87:0] m_tdata;

	sighting_board board;
	logic [47:0] addr_pool[POOL_SIZE];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holdoff_cycles = 0;
	int unsigned cycle_count = 0;

	seen_device_table_lfu uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side: random back-pressure plus a single long hold-off.
	initial begin
		forever begin
			@(posedge clk);
			if (holdoff_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (holdoff_cycles) @(posedge clk);
				holdoff_cycles = 0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			board.check_beat(m_tuser, m_tdata);

	task automatic send_beat(logic mode, logic [47:0] addr, logic [7:0] rssi, logic [3:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {4'b0, idx, rssi, addr};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_beat(mode, addr, rssi, idx);
	endtask

	task automatic send_random_beat();
		logic [63:0] raw;
		logic [47:0] addr;
		int b;
		raw = {$urandom, $urandom};
		addr = raw[47:0];
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
			6, 7: ;
			8: begin
				b = $urandom_range(5);
				addr[8*b +: 8] = 8'h00;
			end
			default: addr = $urandom_range(1) ? '1 : '0;
		endcase
		send_beat(($urandom_range(99) < 20) ? MODE_READ : MODE_REPORT, addr,
			8'($urandom_range(255)), 4'($urandom_range(15)));
	endtask

	task automatic wait_drained();
		while (board.outstanding() != 0) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	initial begin
		int k;
		logic [63:0] raw;
		board = new();
		for (k = 0; k < POOL_SIZE; k++) begin
			raw = {$urandom, $urandom};
			addr_pool[k] = raw[47:0];
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 29;
		recv_idle_pct = 74;
		// reads of an empty table, then the all-zero address
		send_beat(MODE_READ, '0, 8'h00, 4'h0);
		send_beat(MODE_READ, '1, 8'hFF, 4'hF);
		send_beat(MODE_REPORT, 48'h0, 8'h80, 4'h0);

		send_beat(MODE_READ, '0, 8'h00, 4'h0);
		send_beat(MODE_REPORT, 48'hFFFF_FFFF_FFFF, 8'h7F, 4'hF);
		send_beat(MODE_READ, '0, 8'h00, 4'h1);
		send_beat(MODE_READ, '0, 8'h00, 4'h2);
		send_beat(MODE_REPORT, 48'h0000_0000_0001, 8'h01, 4'h0);
		send_beat(MODE_REPORT, 48'h8000_0000_0000, 8'hFF, 4'h0);
		send_beat(MODE_REPORT, 48'h00FF_00FF_00FF, 8'h00, 4'h0);
		send_beat(MODE_REPORT, 48'hFF00_FF00_FF00, 8'h80, 4'h0);
		// fill the remaining slots
		for (k = 0; k < 10; k++)
			send_beat(MODE_REPORT, addr_pool[k], 8'($urandom_range(255)),
				4'($urandom_range(15)));
		send_beat(MODE_REPORT, 48'hFFFF_FFFF_FFFF, 8'h00, 4'h0);
		// table full: a new address takes the first lowest-count slot
		send_beat(MODE_REPORT, 48'h1234_5678_9ABC, 8'hC0, 4'h0);
		send_beat(MODE_READ, '0, 8'h00, 4'hF);

		// hold results back long enough to back up the input
		holdoff_cycles = 400;
		for (k = 0; k < 600; k++)
			send_random_beat();

		send_idle_pct = 74;
		recv_idle_pct = 29;
		for (k = 0; k < 600; k++) begin
			if (k == 300)
				wait_drained();
			send_random_beat();
		end

		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (k = 0; k < 650; k++)
			send_random_beat();
		s_tvalid <= 1'b0;

		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (2 * SCAN_LATENCY) @(posedge clk);
		if (board.failures == 0 && board.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
